### rtl/refd_pkg.sv
// ----------------------------------------------------------------------------
// refd_pkg
// Types, register indexes and fixed-point helpers shared by the enhancement
// factor pipeline.
// ----------------------------------------------------------------------------
package refd_pkg;

	localparam int FRAC      = 30;
	localparam int DIV_STEPS = 30;
	localparam int NUM_LANES = 3;

	typedef logic signed [31:0] coef_t;
	typedef logic [30:0]        scale_t;
	typedef logic [31:0]        grad_t;
	typedef logic [1:0]         order_t;
	typedef logic [31:0]        cfg_data_t;
	typedef logic signed [47:0] out_t;

	// Fraction below one (Q0.30) and a value up to exactly one (Q1.30).
	typedef logic [29:0]        frac_t;
	typedef logic [30:0]        unit_t;
	// Bracket terms in signed Q.28 and the wider derivative sums.
	typedef logic signed [35:0] brk_t;
	typedef logic signed [41:0] gsum_t;

	typedef enum logic [1:0] {
		CFG_COEF_CONST  = 2'd0,
		CFG_COEF_SQUARE = 2'd1,
		CFG_COEF_FOURTH = 2'd2,
		CFG_GRAD_SCALE  = 2'd3
	} cfg_idx_t;

	localparam coef_t  RST_COEF_CONST  = 32'sd268650204;
	localparam coef_t  RST_COEF_SQUARE = 32'sd51700669;
	localparam coef_t  RST_COEF_FOURTH = 32'sd509007312;
	localparam scale_t RST_GRAD_SCALE  = 31'd34434431;

	localparam unit_t       UNIT_ONE  = 31'h4000_0000;
	localparam logic [63:0] DEN_BIAS  = 64'h0001_0000_0000_0000;
	localparam logic [62:0] POS_LIMIT = 63'h0000_7FFF_FFFF_FFFF;
	localparam logic [62:0] NEG_LIMIT = 63'h0000_8000_0000_0000;
	localparam out_t        OUT_MAX   = 48'sh7FFF_FFFF_FFFF;
	localparam out_t        OUT_MIN   = 48'sh8000_0000_0000;

	// Signed times unsigned Q1.30, magnitude truncated toward zero.
	function automatic brk_t mul30(input brk_t a, input unit_t b);
		logic [34:0] mag;
		logic [65:0] prod;
		brk_t        res;
		mag  = a[35] ? 35'(-a) : 35'(a);
		prod = mag * b;
		res  = $signed({1'b0, prod[64:30]});
		return a[35] ? -res : res;
	endfunction

	// Product of two values in [0, 1], rounded down to Q1.30.
	function automatic unit_t pw30(input unit_t a, input unit_t b);
		logic [61:0] prod;
		prod = a * b;
		return prod[60:30];
	endfunction

endpackage

### rtl/rational_enhancement_factor_derivs.sv
// ----------------------------------------------------------------------------
// rational_enhancement_factor_derivs
// Rational enhancement factor f = c0 + u^2 (c1 + c2 u^2), u = s/(1+s),
// s = scale*x, with its first three derivatives in x, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Payload
//  -------   ------------------  -----------------------------------------
//  command   start, busy         grad_in, deriv_order
//  result    done (strobe)       factor_out, first_deriv, second_deriv,
//                                third_deriv
//  config    cfg_we              cfg_idx, cfg_wdata
//
// A new transaction is taken in every clock cycle; busy stays low. Each
// result is shown for exactly one cycle with done high. The quotient u is
// formed by a 30-stage restoring divider (one quotient bit per stage),
// followed by eight stages of powers and brackets and four stages that scale
// the derivatives by powers of the gradient scale and saturate them.
// Reset clears the valid chain and loads the register defaults. The receiver
// cannot stall, so the pipeline never holds: every stage moves every cycle.
//
module rational_enhancement_factor_derivs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  refd_pkg::grad_t      grad_in,
	input  refd_pkg::order_t     deriv_order,
	output logic                 done,
	output refd_pkg::out_t       factor_out,
	output refd_pkg::out_t       first_deriv,
	output refd_pkg::out_t       second_deriv,
	output refd_pkg::out_t       third_deriv,
	input  logic                 cfg_we,
	input  refd_pkg::cfg_idx_t   cfg_idx,
	input  refd_pkg::cfg_data_t  cfg_wdata
);
	import refd_pkg::*;

	// Configuration registers.
	coef_t  coef_const_q, coef_square_q, coef_fourth_q;
	scale_t gradient_scale_q;

	// Powers of the scale, recomputed continuously from the scale register.
	// Both are registered: ss_q from the scale register and s3_q from ss_q.
	logic [61:0] ss_q;
	logic [60:0] s3_q;

	// Valid and order travel along with the data.
	logic   vld_s [1:43];
	order_t ord_s [1:42];

	// Divider stages: stage 1 holds the product, stage k+1 the k-th step.
	logic [63:0] div_rem_s [1:31];
	logic [63:0] div_den_s [1:31];
	frac_t       div_quo_s [1:31];

	// Power and bracket stages.
	unit_t w_s32, w_s33, w_s34, w_s35, w_s36;
	frac_t u_s32, u_s33, u_s34;
	unit_t u2_s32, u2_s33, u2_s34;
	brk_t  cu_s32, cu_s33, cu_s34, cu_s35, cu_s36, cu_s37;
	unit_t w2_s33, w2_s34, w2_s35;
	brk_t  t_s33;
	unit_t w3_s34, w3_s35, w3_s36;
	brk_t  a_s34, b_s34, h_s34;
	unit_t w4_s35, w4_s36;
	brk_t  p_s35, g0m_s35, b_s35;
	unit_t w5_s36, w5_s37;
	brk_t  g0_s36, q1_s36, p_s36, b_s36;
	unit_t w6_s37;
	brk_t  m2a_s37, m2b_s37, m3c_s37, b_s37, g0_s37, q1_s37;
	brk_t  m3a_s38, m3b_s38, m3c_s38, g0_s38, q1_s38;
	gsum_t g2_s38;
	gsum_t g2_s39, g3_s39;
	brk_t  g0_s39, q1_s39;

	// Derivative lanes: magnitude, partial products, scaled magnitude.
	gsum_t       lane_g [0:NUM_LANES-1];
	logic [61:0] lane_sk [0:NUM_LANES-1];
	logic [40:0] mag_s40 [0:NUM_LANES-1];
	logic        neg_s40 [0:NUM_LANES-1];
	logic        neg_s41 [0:NUM_LANES-1];
	logic        neg_s42 [0:NUM_LANES-1];
	logic [71:0] phi_s41 [0:NUM_LANES-1];
	logic [71:0] plo_s41 [0:NUM_LANES-1];
	logic [62:0] shv_s42 [0:NUM_LANES-1];
	brk_t        g0_s40, g0_s41, g0_s42;
	out_t        der_sat [0:NUM_LANES-1];
	out_t        fac_s43, d1_s43, d2_s43, d3_s43;

	// ------------------------------------------------------------------
	// Config port. Users must write only with no item in flight; not enforced.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_const_q     <= RST_COEF_CONST;
			coef_square_q    <= RST_COEF_SQUARE;
			coef_fourth_q    <= RST_COEF_FOURTH;
			gradient_scale_q <= RST_GRAD_SCALE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_COEF_CONST:  coef_const_q     <= coef_t'(cfg_wdata);
				CFG_COEF_SQUARE: coef_square_q    <= coef_t'(cfg_wdata);
				CFG_COEF_FOURTH: coef_fourth_q    <= coef_t'(cfg_wdata);
				CFG_GRAD_SCALE:  gradient_scale_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ss_q <= gradient_scale_q * gradient_scale_q;
		s3_q <= ss_q[61:32] * gradient_scale_q;
	end

	// ------------------------------------------------------------------
	// Valid chain. Every transaction on the command port is taken.
	// ------------------------------------------------------------------
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 43; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start;
			for (int i = 2; i <= 43; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		ord_s[1] <= deriv_order;
		for (int i = 2; i <= 42; i++) begin
			ord_s[i] <= ord_s[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: s = scale * x, exact in Q16.48, and the divisor 1 + s.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		div_rem_s[1] <= 64'(gradient_scale_q * grad_in);
		div_den_s[1] <= 64'(gradient_scale_q * grad_in) + DEN_BIAS;
		div_quo_s[1] <= '0;
	end

	// ------------------------------------------------------------------
	// Stages 2 to 31: restoring division, one quotient bit per stage.
	// The shifted remainder keeps its carry bit in a 65-bit compare.
	// ------------------------------------------------------------------
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [64:0] rr;
		logic        ge;
		always_comb begin
			rr = {div_rem_s[k], 1'b0};
			ge = rr >= {1'b0, div_den_s[k]};
		end
		always_ff @(posedge clk) begin
			div_rem_s[k+1] <= ge ? 64'(rr - {1'b0, div_den_s[k]}) : rr[63:0];
			div_den_s[k+1] <= div_den_s[k];
			div_quo_s[k+1] <= {div_quo_s[k][28:0], ge};
		end
	end

	// ------------------------------------------------------------------
	// Stages 32 to 39: powers of u and w = 1 - u, brackets and the sums
	// for f and its derivatives in u-space. Every multiply is registered.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		// Stage 32.
		u_s32  <= div_quo_s[31];
		w_s32  <= UNIT_ONE - {1'b0, div_quo_s[31]};
		u2_s32 <= pw30({1'b0, div_quo_s[31]}, {1'b0, div_quo_s[31]});
		cu_s32 <= mul30(brk_t'(coef_fourth_q), {1'b0, div_quo_s[31]});

		// Stage 33.
		w2_s33 <= pw30(w_s32, w_s32);
		t_s33  <= mul30(brk_t'(coef_fourth_q), u2_s32);
		w_s33  <= w_s32;
		u_s33  <= u_s32;
		u2_s33 <= u2_s32;
		cu_s33 <= cu_s32;

		// Stage 34: brackets c1 + t, c1 + 2t, c1 + 6t.
		w3_s34 <= pw30(w2_s33, w_s33);
		h_s34  <= brk_t'(coef_square_q) + t_s33;
		a_s34  <= brk_t'(coef_square_q) + (t_s33 <<< 1);
		b_s34  <= brk_t'(coef_square_q) + (t_s33 <<< 2) + (t_s33 <<< 1);
		w_s34  <= w_s33;
		w2_s34 <= w2_s33;
		u_s34  <= u_s33;
		u2_s34 <= u2_s33;
		cu_s34 <= cu_s33;

		// Stage 35.
		w4_s35  <= pw30(w3_s34, w_s34);
		p_s35   <= mul30(a_s34, {1'b0, u_s34});
		g0m_s35 <= mul30(h_s34, u2_s34);
		w_s35   <= w_s34;
		w2_s35  <= w2_s34;
		w3_s35  <= w3_s34;
		b_s35   <= b_s34;
		cu_s35  <= cu_s34;

		// Stage 36.
		w5_s36 <= pw30(w4_s35, w_s35);
		g0_s36 <= brk_t'(coef_const_q) + g0m_s35;
		q1_s36 <= mul30(p_s35, w2_s35);
		w_s36  <= w_s35;
		w3_s36 <= w3_s35;
		w4_s36 <= w4_s35;
		p_s36  <= p_s35;
		b_s36  <= b_s35;
		cu_s36 <= cu_s35;

		// Stage 37.
		w6_s37  <= pw30(w5_s36, w_s36);
		m2a_s37 <= mul30(b_s36, w4_s36);
		m2b_s37 <= mul30(p_s36, w3_s36);
		m3c_s37 <= mul30(p_s36, w4_s36);
		w5_s37  <= w5_s36;
		b_s37   <= b_s36;
		cu_s37  <= cu_s36;
		g0_s37  <= g0_s36;
		q1_s37  <= q1_s36;

		// Stage 38: second derivative sum is complete here.
		m3a_s38 <= mul30(cu_s37, w6_s37);
		m3b_s38 <= mul30(b_s37, w5_s37);
		g2_s38  <= (gsum_t'(m2a_s37) <<< 1) - (gsum_t'(m2b_s37) <<< 2);
		m3c_s38 <= m3c_s37;
		g0_s38  <= g0_s37;
		q1_s38  <= q1_s37;

		// Stage 39: third derivative sum.
		g3_s39 <= gsum_t'(m3a_s38) * 42'sd24 - gsum_t'(m3b_s38) * 42'sd12
			+ gsum_t'(m3c_s38) * 42'sd12;
		g2_s39 <= g2_s38;
		g0_s39 <= g0_s38;
		q1_s39 <= q1_s38;
	end

	// ------------------------------------------------------------------
	// Stages 40 to 43: each derivative is scaled by its power of the
	// gradient scale in sign-magnitude form. The Q.52 scale power is split
	// in two halves so that each partial product stays narrow.
	// ------------------------------------------------------------------
	always_comb begin
		lane_g[0]  = gsum_t'(q1_s39) <<< 1;
		lane_g[1]  = g2_s39;
		lane_g[2]  = g3_s39;
		lane_sk[0] = {7'b0, gradient_scale_q, 24'b0};
		lane_sk[1] = {4'b0, ss_q[61:4]};
		lane_sk[2] = {1'b0, s3_q};
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < NUM_LANES; n++) begin
			// Stage 40.
			neg_s40[n] <= lane_g[n][41];
			mag_s40[n] <= lane_g[n][41] ? 41'(-lane_g[n]) : 41'(lane_g[n]);
			// Stage 41.
			phi_s41[n] <= mag_s40[n] * lane_sk[n][61:31];
			plo_s41[n] <= mag_s40[n] * lane_sk[n][30:0];
			neg_s41[n] <= neg_s40[n];
			// Stage 42: reassemble and drop 40 fraction bits.
			shv_s42[n] <= 63'(({31'b0, phi_s41[n]} << 31) + {31'b0, plo_s41[n]} >> 40);
			neg_s42[n] <= neg_s41[n];
		end
		g0_s40 <= g0_s39;
		g0_s41 <= g0_s40;
		g0_s42 <= g0_s41;
	end

	// Saturation to the signed Q8.40 range, applied to the magnitude.
	always_comb begin
		for (int n = 0; n < NUM_LANES; n++) begin
			if (neg_s42[n]) begin
				der_sat[n] = (shv_s42[n] > NEG_LIMIT) ? OUT_MIN : -out_t'(shv_s42[n]);
			end else begin
				der_sat[n] = (shv_s42[n] > POS_LIMIT) ? OUT_MAX : out_t'(shv_s42[n]);
			end
		end
	end

	// Stage 43: output registers. Derivatives above the order read zero.
	// The factor itself cannot leave the output range, so it is a shift.
	always_ff @(posedge clk) begin
		fac_s43 <= out_t'(g0_s42) <<< 12;
		d1_s43  <= (ord_s[42] >= 2'd1) ? der_sat[0] : '0;
		d2_s43  <= (ord_s[42] >= 2'd2) ? der_sat[1] : '0;
		d3_s43  <= (ord_s[42] == 2'd3) ? der_sat[2] : '0;
	end

	assign done         = vld_s[43];
	assign factor_out   = fac_s43;
	assign first_deriv  = d1_s43;
	assign second_deriv = d2_s43;
	assign third_deriv  = d3_s43;

endmodule
